// ===== design/cdd_pkg.sv =====
`default_nettype none

package cdd_pkg;

    // Field widths of the date and result ports.
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 22;

    // Largest year accepted unless the top level is told otherwise.
    localparam int YEAR_MAX_DEFAULT = 9999;

    // Day numbers of 14-bit years need one bit more than the count.
    localparam int DAYNUM_W = 23;

    // Division by 100 as a multiplication by a reciprocal; exact below 43690.
    localparam int RECIP_100   = 5243;
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 19;
    localparam int QUOT_W      = 8;
    localparam int PROD_W      = YEAR_W + RECIP_W;

    // Month-of-year offset width and the sum of the small day-number terms.
    localparam int OFFSET_W = 9;
    localparam int CORR_W   = 13;

    localparam int DAYS_PER_YEAR = 365;
    localparam int CENTURY       = 100;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // Day number and validity of one date, passed to the difference stage.
    typedef struct packed {
        logic [DAYNUM_W-1:0] day_num;
        logic                ok;
    } date_info_t;

    // Length of a month in a common year; zero for a month that does not exist.
    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1:    len = 5'd31;
            4'd2:    len = 5'd28;
            4'd3:    len = 5'd31;
            4'd4:    len = 5'd30;
            4'd5:    len = 5'd31;
            4'd6:    len = 5'd30;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd31;
            4'd9:    len = 5'd30;
            4'd10:   len = 5'd31;
            4'd11:   len = 5'd30;
            4'd12:   len = 5'd31;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    // Days from 1 March to the first of the month, the year running March to February.
    function automatic logic [OFFSET_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
        logic [OFFSET_W-1:0] off;
        case (m)
            4'd3:    off = 9'd0;
            4'd4:    off = 9'd31;
            4'd5:    off = 9'd61;
            4'd6:    off = 9'd92;
            4'd7:    off = 9'd122;
            4'd8:    off = 9'd153;
            4'd9:    off = 9'd184;
            4'd10:   off = 9'd214;
            4'd11:   off = 9'd245;
            4'd12:   off = 9'd275;
            4'd1:    off = 9'd306;
            4'd2:    off = 9'd337;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

endpackage

`default_nettype wire

// ===== design/calendar_date_difference_core.sv =====
`default_nettype none

// Channel   Handshake            Fields
// -------   ------------------   ---------------------------------------------
// input     start, busy          first_year/month/day, second_year/month/day
// result    done (one cycle)     day_count, date_error
//
// A taken item goes through the day-number stages, then the result register.
// A new item may enter in every cycle; busy is always low.
// The depth is set by the reciprocal multiplications, the leap and day checks,
// the day-number adder and the final subtraction, one register stage each.
// Reset clears only the valid bits; items in flight are dropped.
// The receiver cannot stall, so nothing in the pipeline ever waits.
module calendar_date_difference_core #(
    parameter int YEAR_MAX = cdd_pkg::YEAR_MAX_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [cdd_pkg::YEAR_W-1:0]  first_year,
    input  wire logic [cdd_pkg::MONTH_W-1:0] first_month,
    input  wire logic [cdd_pkg::DAY_W-1:0]   first_day,
    input  wire logic [cdd_pkg::YEAR_W-1:0]  second_year,
    input  wire logic [cdd_pkg::MONTH_W-1:0] second_month,
    input  wire logic [cdd_pkg::DAY_W-1:0]   second_day,
    output logic                             done,
    output logic [cdd_pkg::COUNT_W-1:0]      day_count,
    output logic                             date_error
);

    localparam int STAGES = 3;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic              accept;

    cdd_pkg::date_info_t first_info;
    cdd_pkg::date_info_t second_info;

    // The pipeline never holds, so an item is taken whenever start is high.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Valid bits travel alongside the day-number stages.
    assign valid_next = {valid_reg[STAGES-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    cdd_day_number #(
        .YEAR_MAX (YEAR_MAX)
    ) u_first (
        .clk   (clk),
        .year  (first_year),
        .month (first_month),
        .day   (first_day),
        .info  (first_info)
    );

    cdd_day_number #(
        .YEAR_MAX (YEAR_MAX)
    ) u_second (
        .clk   (clk),
        .year  (second_year),
        .month (second_month),
        .day   (second_day),
        .info  (second_info)
    );

    cdd_difference u_diff (
        .clk         (clk),
        .rst_n       (rst_n),
        .valid       (valid_reg[STAGES-1]),
        .first_info  (first_info),
        .second_info (second_info),
        .done        (done),
        .day_count   (day_count),
        .date_error  (date_error)
    );

    // An accepted item always yields its result on done.
    assert property (@(posedge clk) disable iff (!rst_n) accept |-> ##4 done)
        else $error("accepted item produced no result on time");

    // No result appears without an earlier accepted item.
    assert property (@(posedge clk) disable iff (!rst_n) !accept |-> ##4 !done)
        else $error("result produced without an accepted item");

    // A flagged result always carries a zero count.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (done && date_error) |-> (day_count == '0))
        else $error("invalid date result with non-zero count");

endmodule

`default_nettype wire

// ===== design/cdd_day_number.sv =====
`default_nettype none

// Three-stage pipeline that turns one date into a day number and a validity flag.
module cdd_day_number #(
    parameter int YEAR_MAX = cdd_pkg::YEAR_MAX_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic [cdd_pkg::YEAR_W-1:0]  year,
    input  wire logic [cdd_pkg::MONTH_W-1:0] month,
    input  wire logic [cdd_pkg::DAY_W-1:0]   day,
    output cdd_pkg::date_info_t              info
);

    localparam int YW = cdd_pkg::YEAR_W;
    localparam int QW = cdd_pkg::QUOT_W;
    localparam int PW = cdd_pkg::PROD_W;
    localparam int NW = cdd_pkg::DAYNUM_W;
    localparam int CW = cdd_pkg::CORR_W;
    localparam int CMP_W = 17;

    // Stage one registers.
    logic [YW-1:0]                  a_y_reg;
    logic [YW-1:0]                  a_yy_reg;
    logic [QW-1:0]                  a_qy_reg;
    logic [QW-1:0]                  a_qyy_reg;
    logic                           a_feb_reg;
    logic [cdd_pkg::DAY_W-1:0]      a_len_reg;
    logic [cdd_pkg::OFFSET_W-1:0]   a_off_reg;
    logic [cdd_pkg::DAY_W-1:0]      a_d_reg;
    logic                           a_ok_reg;

    // Stage two registers.
    logic [NW-1:0] b_mul_reg;
    logic [CW-1:0] b_corr_reg;
    logic [QW-1:0] b_sub_reg;
    logic          b_ok_reg;

    // Stage three register.
    cdd_pkg::date_info_t c_info_reg;

    logic [YW-1:0] yy_next;
    logic [PW-1:0] prod_y;
    logic [PW-1:0] prod_yy;
    logic          year_ok;
    logic          month_ok;

    logic [YW-1:0]             cent_mul;
    logic                      leap;
    logic [cdd_pkg::DAY_W-1:0] len_eff;
    logic                      day_ok;

    // Stage one: year before March, quotients by 100, table lookups, range checks.
    always_comb
    begin
        yy_next  = (month <= cdd_pkg::MONTH_FEB) ? year - YW'(1) : year;
        prod_y   = PW'(year) * PW'(cdd_pkg::RECIP_100);
        prod_yy  = PW'(yy_next) * PW'(cdd_pkg::RECIP_100);
        year_ok  = (year != '0) && (CMP_W'(year) <= CMP_W'(YEAR_MAX));
        month_ok = month inside {[cdd_pkg::MONTH_JAN:cdd_pkg::MONTH_DEC]};
    end

    always_ff @(posedge clk)
    begin
        a_y_reg   <= year;
        a_yy_reg  <= yy_next;
        a_qy_reg  <= prod_y[cdd_pkg::RECIP_SHIFT +: QW];
        a_qyy_reg <= prod_yy[cdd_pkg::RECIP_SHIFT +: QW];
        a_feb_reg <= (month == cdd_pkg::MONTH_FEB);
        a_len_reg <= cdd_pkg::month_length(month);
        a_off_reg <= cdd_pkg::month_offset(month);
        a_d_reg   <= day;
        a_ok_reg  <= year_ok && month_ok;
    end

    // Stage two: Gregorian leap rule, day check, days of whole years and small terms.
    always_comb
    begin
        cent_mul = YW'(a_qy_reg) * YW'(cdd_pkg::CENTURY);
        leap     = (a_y_reg[1:0] == 2'b00) &&
                   ((a_y_reg != cent_mul) || (a_qy_reg[1:0] == 2'b00));
        len_eff  = a_len_reg + cdd_pkg::DAY_W'(a_feb_reg && leap);
        day_ok   = (a_d_reg != '0) && (a_d_reg <= len_eff);
    end

    always_ff @(posedge clk)
    begin
        b_mul_reg  <= NW'(a_yy_reg) * NW'(cdd_pkg::DAYS_PER_YEAR);
        b_corr_reg <= CW'(a_yy_reg >> 2) + CW'(a_qyy_reg >> 2) + CW'(a_off_reg)
                      + CW'(a_d_reg);
        b_sub_reg  <= a_qyy_reg + QW'(1);
        b_ok_reg   <= a_ok_reg && day_ok;
    end

    // Stage three: the day number itself.
    always_ff @(posedge clk)
    begin
        c_info_reg.day_num <= b_mul_reg + NW'(b_corr_reg) - NW'(b_sub_reg);
        c_info_reg.ok      <= b_ok_reg;
    end

    assign info = c_info_reg;

endmodule

`default_nettype wire

// ===== design/cdd_difference.sv =====
`default_nettype none

// Final stage: absolute difference of two day numbers and the result register.
module cdd_difference (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        valid,
    input  wire cdd_pkg::date_info_t         first_info,
    input  wire cdd_pkg::date_info_t         second_info,
    output logic                             done,
    output logic [cdd_pkg::COUNT_W-1:0]      day_count,
    output logic                             date_error
);

    localparam int NW = cdd_pkg::DAYNUM_W;

    logic                        done_reg;
    logic [cdd_pkg::COUNT_W-1:0] count_reg;
    logic                        error_reg;

    logic [NW:0]                 fwd_diff;
    logic [NW:0]                 rev_diff;
    logic [NW-1:0]               abs_diff;
    logic                        both_ok;
    logic [cdd_pkg::COUNT_W-1:0] count_next;

    // Both differences at once; the borrow of one picks the other.
    always_comb
    begin
        fwd_diff   = {1'b0, first_info.day_num} - {1'b0, second_info.day_num};
        rev_diff   = {1'b0, second_info.day_num} - {1'b0, first_info.day_num};
        abs_diff   = fwd_diff[NW] ? rev_diff[NW-1:0] : fwd_diff[NW-1:0];
        both_ok    = first_info.ok && second_info.ok;
        count_next = both_ok ? abs_diff[cdd_pkg::COUNT_W-1:0] : '0;
    end

    // The strobe is control state; the result fields need no reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg <= count_next;
        error_reg <= !both_ok;
    end

    assign done       = done_reg;
    assign day_count  = count_reg;
    assign date_error = error_reg;

endmodule

`default_nettype wire

// ===== tb/calendar_date_difference_core_test.sv =====
module calendar_date_difference_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import cdd_pkg::*;

    localparam int YEAR_LIMIT = YEAR_MAX_DEFAULT;
    localparam int PIPE_DEPTH = 4;

    // Expected day count and error flag of one date pair.
    typedef struct {
        logic [COUNT_W-1:0] count;
        logic               err;
    } day_gap_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [YEAR_W-1:0]  first_year = '0;
    logic [MONTH_W-1:0] first_month = '0;
    logic [DAY_W-1:0]   first_day = '0;
    logic [YEAR_W-1:0]  second_year = '0;
    logic [MONTH_W-1:0] second_month = '0;
    logic [DAY_W-1:0]   second_day = '0;
    logic               done;
    logic [COUNT_W-1:0] day_count;
    logic               date_error;

    day_gap_t expected_gaps[$];
    int       failures = 0;
    int       pairs_sent = 0;
    int       invalid_sent = 0;
    int       gaps_compared = 0;
    int       burst_left = 1;

    calendar_date_difference_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .first_year   (first_year),
        .first_month  (first_month),
        .first_day    (first_day),
        .second_year  (second_year),
        .second_month (second_month),
        .second_day   (second_day),
        .done         (done),
        .day_count    (day_count),
        .date_error   (date_error)
    );

    // Free-running clock with a 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Gregorian leap year: every fourth year, except centuries not divisible by 400.
    function automatic bit is_leap(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    // Length of a month that exists; the caller keeps m within 1..12.
    function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
        case (m)
            4, 6, 9, 11: return 30;
            MONTH_FEB:   return is_leap(y) ? 29 : 28;
            default:     return 31;
        endcase
    endfunction

    function automatic bit valid_date(input int unsigned y, input int unsigned m,
                                      input int unsigned d);
        if (y < 1 || y > YEAR_LIMIT)
            return 1'b0;
        if (m < MONTH_JAN || m > MONTH_DEC)
            return 1'b0;
        return (d >= 1) && (d <= days_in_month(y, m));
    endfunction

    // Days from the start of year 1 to the given date, counting whole years then months.
    function automatic int unsigned serial_day(input int unsigned y, input int unsigned m,
                                               input int unsigned d);
        int unsigned past;
        int unsigned total;
        past  = y - 1;
        total = past * 365 + past / 4 - past / 100 + past / 400;
        for (int unsigned k = MONTH_JAN; k < m; k++)
            total += days_in_month(y, k);
        return total + d;
    endfunction

    // Expected result of one date pair: an invalid date gives the flag and a zero count.
    function automatic day_gap_t predict_day_gap(input int unsigned y1, input int unsigned m1,
                                                 input int unsigned d1, input int unsigned y2,
                                                 input int unsigned m2, input int unsigned d2);
        day_gap_t    gap;
        int unsigned a;
        int unsigned b;
        if (!valid_date(y1, m1, d1) || !valid_date(y2, m2, d2))
        begin
            gap.count = '0;
            gap.err   = 1'b1;
            return gap;
        end
        a = serial_day(y1, m1, d1);
        b = serial_day(y2, m2, d2);
        gap.count = COUNT_W'((a >= b) ? a - b : b - a);
        gap.err   = 1'b0;
        return gap;
    endfunction

    // Random year, leaning towards the ends of the range and century boundaries.
    function automatic int unsigned pick_year();
        int unsigned century;
        case ($urandom_range(0, 5))
            0:       return $urandom_range(1, 8);
            1:       return $urandom_range(YEAR_LIMIT - 7, YEAR_LIMIT);
            2:
            begin
                century = 100 * $urandom_range(1, YEAR_LIMIT / 100);
                return (century - 1) + $urandom_range(0, 2);
            end
            default: return $urandom_range(1, YEAR_LIMIT);
        endcase
    endfunction

    // After each burst the sender drops start for a random pause.
    task automatic pace_sender();
        if (--burst_left > 0)
            return;
        @(negedge clk);
        start = 1'b0;
        repeat ($urandom_range(0, 5)) @(posedge clk);
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                 : $urandom_range(1, 30);
    endtask

    // Present one date pair and hold it until the block takes it.
    task automatic send_dates(input logic [YEAR_W-1:0] y1, input logic [MONTH_W-1:0] m1,
                              input logic [DAY_W-1:0] d1, input logic [YEAR_W-1:0] y2,
                              input logic [MONTH_W-1:0] m2, input logic [DAY_W-1:0] d2);
        day_gap_t gap;
        @(negedge clk);
        first_year   = y1;
        first_month  = m1;
        first_day    = d1;
        second_year  = y2;
        second_month = m2;
        second_day   = d2;
        start        = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        gap = predict_day_gap(y1, m1, d1, y2, m2, d2);
        expected_gaps.push_back(gap);
        pairs_sent++;
        if (gap.err)
            invalid_sent++;
        pace_sender();
    endtask

    // Stop sending and let every outstanding result come back.
    task automatic wait_for_results();
        @(negedge clk);
        start = 1'b0;
        while (expected_gaps.size() != 0)
            @(posedge clk);
    endtask

    // Identical dates, the widest span in both orders, the last valid year and a year boundary.
    task automatic test_equal_and_extremes();
        send_dates(1, 1, 1, 1, 1, 1);
        send_dates(YEAR_LIMIT, 12, 31, YEAR_LIMIT, 12, 31);
        send_dates(1, 1, 1, YEAR_LIMIT, 12, 31);
        send_dates(YEAR_LIMIT, 12, 31, 1, 1, 1);
        send_dates(1, 12, 31, 2, 1, 1);
    endtask

    // The 29th of February across ordinary, century and four-hundred-year cases.
    task automatic test_leap_years();
        send_dates(2000, 2, 29, 2000, 3, 1);
        send_dates(2024, 2, 29, 2023, 2, 28);
        send_dates(1900, 2, 28, 1900, 3, 1);
        send_dates(1900, 2, 29, 1900, 3, 1);
        send_dates(2023, 2, 29, 2023, 1, 1);
        send_dates(2100, 3, 1, 2099, 2, 28);
        send_dates(400, 2, 29, 1600, 2, 29);
    endtask

    // Every way a date can be out of range, on either side of the pair.
    task automatic test_invalid_dates();
        send_dates(2020, 0, 10, 2020, 1, 1);
        send_dates(2020, 1, 1, 2020, 13, 1);
        send_dates(2020, 15, 31, 2020, 1, 1);
        send_dates(2020, 5, 0, 2020, 5, 1);
        send_dates(2020, 4, 31, 2020, 5, 1);
        send_dates(2020, 5, 1, 2020, 6, 31);
        send_dates(0, 6, 15, 2020, 6, 15);
        send_dates(2020, 6, 15, YEAR_LIMIT + 1, 1, 1);
        send_dates(16383, 15, 31, 16383, 15, 31);
        send_dates(2020, 1, 31, 2020, 2, 30);
    endtask

    // Valid pairs: half with two independent years, half within a year or so of each other.
    task automatic test_random_valid(input int count);
        int unsigned y1;
        int unsigned m1;
        int unsigned d1;
        int unsigned y2;
        int unsigned m2;
        int unsigned d2;
        for (int n = 0; n < count; n++)
        begin
            y1 = pick_year();
            m1 = $urandom_range(MONTH_JAN, MONTH_DEC);
            d1 = $urandom_range(1, days_in_month(y1, m1));
            if ($urandom_range(0, 1) == 0)
                y2 = pick_year();
            else if (y1 == 1)
                y2 = y1 + $urandom_range(0, 1);
            else if (y1 == YEAR_LIMIT)
                y2 = y1 - $urandom_range(0, 1);
            else
                y2 = y1 + $urandom_range(0, 2) - 1;
            m2 = $urandom_range(MONTH_JAN, MONTH_DEC);
            d2 = $urandom_range(1, days_in_month(y2, m2));
            send_dates(y1, m1, d1, y2, m2, d2);
        end
    endtask

    // Arbitrary field values and dates with a single field out of range.
    task automatic test_random_noise(input int count);
        int unsigned y;
        int unsigned m;
        int unsigned d;
        for (int n = 0; n < count; n++)
        begin
            y = pick_year();
            m = $urandom_range(MONTH_JAN, MONTH_DEC);
            d = $urandom_range(1, days_in_month(y, m));
            case ($urandom_range(0, 3))
                0:
                    send_dates($urandom_range(0, 16383), $urandom_range(0, 15),
                               $urandom_range(0, 31), $urandom_range(0, 16383),
                               $urandom_range(0, 15), $urandom_range(0, 31));
                1:
                    send_dates(y, m, days_in_month(y, m) + 1, pick_year(), MONTH_JAN, 1);
                2:
                    send_dates(pick_year(), MONTH_JAN, 1, y,
                               ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(13, 15), d);
                default:
                    send_dates(($urandom_range(0, 1) == 0) ? 0
                                                           : $urandom_range(YEAR_LIMIT + 1, 16383),
                               m, d, pick_year(), m, 1);
            endcase
        end
    endtask

    // Each result is matched against the oldest outstanding expectation.
    always @(posedge clk)
    begin
        day_gap_t want;
        if (rst_n && done)
        begin
            if (expected_gaps.size() == 0)
            begin
                $error("Result with no item outstanding: day_count %0d, date_error %0b",
                       day_count, date_error);
                failures++;
            end
            else
            begin
                want = expected_gaps.pop_front();
                gaps_compared++;
                if (day_count !== want.count)
                begin
                    $error("day_count: expected %0d, got %0d", want.count, day_count);
                    failures++;
                end
                if (date_error !== want.err)
                begin
                    $error("date_error: expected %0b, got %0b", want.err, date_error);
                    failures++;
                end
            end
        end
    end

    // Test sequence.
    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_equal_and_extremes();
        test_leap_years();
        test_invalid_dates();
        wait_for_results();
        test_random_valid(600);
        wait_for_results();
        test_random_noise(300);
        test_random_valid(350);
        wait_for_results();
        repeat (2 * PIPE_DEPTH) @(posedge clk);

        $display("Sent %0d date pairs, %0d of them with an invalid date; %0d results compared.",
                 pairs_sent, invalid_sent, gaps_compared);
        $display("Spans ran from equal dates to the full range of years, leap days included.");
        if (failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Guard against a hang: the run is stopped with a failure if it does not finish first.
    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
